// ===== src/mts_pkg.sv =====
// mts_pkg: shared types and constants of the max tracking stack
// command and status codes, controller states and controller to datapath structs
// no dependencies
package mts_pkg;

	localparam int DEF_STACK_DEPTH = 256;
	localparam int DEF_VALUE_WIDTH = 32;

	localparam int KIND_W   = 3;
	localparam int DATA_W   = 32;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 9;

	localparam logic [KIND_W-1:0] KIND_PUSH     = 3'd0;
	localparam logic [KIND_W-1:0] KIND_POP      = 3'd1;
	localparam logic [KIND_W-1:0] KIND_TOP      = 3'd2;
	localparam logic [KIND_W-1:0] KIND_PEEK_MAX = 3'd3;
	localparam logic [KIND_W-1:0] KIND_POP_MAX  = 3'd4;

	localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_SEARCH,
		S_SHIFT,
		S_WAIT
	} fsm_state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_ACCEPT,
		OP_EXEC,
		OP_SEARCH_START,
		OP_STEP_DOWN,
		OP_SHIFT_START,
		OP_SHIFT,
		OP_POP_DONE,
		OP_LOAD_PEND
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic   finish;
	} ctl_cmd_t;

	typedef struct packed {
		logic exec_popmax;
		logic found;
		logic at_top;
		logic shift_last;
		logic out_free;
	} dp_status_t;

endpackage

// ===== src/mts_in_if.sv =====
// mts_in_if: command channel of the max tracking stack
// depends on mts_pkg
interface mts_in_if import mts_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic signed [DATA_W-1:0] push_value;

	modport source (output valid, output kind, output push_value, input ready);
	modport sink (input valid, input kind, input push_value, output ready);
endinterface

// ===== src/mts_out_if.sv =====
// mts_out_if: result channel of the max tracking stack
// depends on mts_pkg
interface mts_out_if import mts_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] result_value;
	logic [STATUS_W-1:0]      status;
	logic [COUNT_W-1:0]       entry_count;

	modport source (output valid, output result_value, output status, output entry_count,
		input ready);
	modport sink (input valid, input result_value, input status, input entry_count,
		output ready);
endinterface

// ===== src/mts_ctrl.sv =====
// mts_ctrl: sequencing state machine of the max tracking stack
// depends on mts_pkg; drives mts_datapath through ctl_cmd_t
module mts_ctrl import mts_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  dp_status_t st,
	output ctl_cmd_t   cmd
);

	fsm_state_t state_q;
	fsm_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_EXEC;
			end
			S_EXEC: begin
				if (st.exec_popmax) state_d = S_SEARCH;
				else state_d = st.out_free ? S_IDLE : S_WAIT;
			end
			S_SEARCH: begin
				if (st.found) begin
					if (st.at_top) state_d = st.out_free ? S_IDLE : S_WAIT;
					else state_d = S_SHIFT;
				end
			end
			S_SHIFT: begin
				if (st.shift_last) state_d = st.out_free ? S_IDLE : S_WAIT;
			end
			S_WAIT: begin
				if (st.out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_ready   = 1'b0;
		cmd.op     = OP_NONE;
		cmd.finish = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) cmd.op = OP_ACCEPT;
			end
			S_EXEC: begin
				if (st.exec_popmax) begin
					cmd.op = OP_SEARCH_START;
				end else begin
					cmd.op     = OP_EXEC;
					cmd.finish = 1'b1;
				end
			end
			S_SEARCH: begin
				if (st.found) begin
					if (st.at_top) begin
						cmd.op     = OP_POP_DONE;
						cmd.finish = 1'b1;
					end else begin
						cmd.op = OP_SHIFT_START;
					end
				end else begin
					cmd.op = OP_STEP_DOWN;
				end
			end
			S_SHIFT: begin
				cmd.op     = OP_SHIFT;
				cmd.finish = st.shift_last;
			end
			S_WAIT: begin
				if (st.out_free) cmd.op = OP_LOAD_PEND;
			end
			default: cmd.op = OP_NONE;
		endcase
	end

endmodule

// ===== src/mts_datapath.sv =====
// mts_datapath: value and running maximum stores, entry count and result register
// depends on mts_pkg; commanded by mts_ctrl
module mts_datapath import mts_pkg::*; #(
	parameter int STACK_DEPTH = DEF_STACK_DEPTH,
	parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [KIND_W-1:0]        kind,
	input  logic signed [DATA_W-1:0] push_value,
	input  logic                     out_ready,
	input  ctl_cmd_t                 cmd,
	output dp_status_t               st,
	output logic                     out_valid,
	output logic signed [DATA_W-1:0] result_value,
	output logic [STATUS_W-1:0]      status,
	output logic [COUNT_W-1:0]       entry_count
);

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(STACK_DEPTH + 1);

	logic [VALUE_WIDTH-1:0] value_store [STACK_DEPTH];
	logic [VALUE_WIDTH-1:0] running_max_store [STACK_DEPTH];

	logic [VALUE_WIDTH-1:0] rd_val_q;
	logic [VALUE_WIDTH-1:0] rd_max_q;
	logic [CW-1:0]          count_q;
	logic [KIND_W-1:0]      kind_q;
	logic [VALUE_WIDTH-1:0] val_q;
	logic [AW-1:0]          idx_q;
	logic [VALUE_WIDTH-1:0] mx_q;
	logic [VALUE_WIDTH-1:0] run_q;
	logic                   out_valid_q;
	logic [DATA_W-1:0]      out_val_q;
	logic [STATUS_W-1:0]    out_stat_q;
	logic [COUNT_W-1:0]     out_cnt_q;
	logic [DATA_W-1:0]      pend_val_q;
	logic [STATUS_W-1:0]    pend_stat_q;
	logic [COUNT_W-1:0]     pend_cnt_q;

	logic [VALUE_WIDTH-1:0] push_v;
	logic [AW-1:0]          top_idx;
	logic                   empty;
	logic                   full;
	logic                   out_free;
	logic [AW-1:0]          rd_addr_v;
	logic [AW-1:0]          rd_addr_m;
	logic                   we;
	logic [AW-1:0]          wr_addr;
	logic [VALUE_WIDTH-1:0] wr_val;
	logic [VALUE_WIDTH-1:0] place_v;
	logic [VALUE_WIDTH-1:0] place_prev;
	logic                   place_has_prev;
	logic [VALUE_WIDTH-1:0] place_max;
	logic [VALUE_WIDTH-1:0] bus_val;
	logic [STATUS_W-1:0]    bus_stat;
	logic [CW-1:0]          nxt_count;
	logic [DATA_W-1:0]      bus_val32;
	logic [COUNT_W-1:0]     bus_cnt;

	generate
		if (VALUE_WIDTH <= DATA_W) begin : g_push_narrow
			assign push_v = push_value[VALUE_WIDTH-1:0];
		end else begin : g_push_wide
			assign push_v = {{(VALUE_WIDTH-DATA_W){1'b0}}, push_value};
		end
		if (VALUE_WIDTH >= DATA_W) begin : g_res_trunc
			assign bus_val32 = bus_val[DATA_W-1:0];
		end else begin : g_res_sext
			assign bus_val32 = {{(DATA_W-VALUE_WIDTH){bus_val[VALUE_WIDTH-1]}}, bus_val};
		end
		if (CW >= COUNT_W) begin : g_cnt_trunc
			assign bus_cnt = nxt_count[COUNT_W-1:0];
		end else begin : g_cnt_ext
			assign bus_cnt = {{(COUNT_W-CW){1'b0}}, nxt_count};
		end
	endgenerate

	assign top_idx  = AW'(count_q - 1'b1);
	assign empty    = (count_q == '0);
	assign full     = (count_q == CW'(STACK_DEPTH));
	assign out_free = !out_valid_q || out_ready;

	// entry placement with its running maximum
	always_comb begin
		if (cmd.op == OP_SHIFT) begin
			place_v        = rd_val_q;
			place_prev     = run_q;
			place_has_prev = (idx_q != '0);
		end else begin
			place_v        = val_q;
			place_prev     = rd_max_q;
			place_has_prev = !empty;
		end
		if (place_has_prev && ($signed(place_prev) > $signed(place_v))) place_max = place_prev;
		else place_max = place_v;
	end

	always_comb begin
		rd_addr_v = top_idx;
		rd_addr_m = top_idx;
		we        = 1'b0;
		wr_addr   = top_idx;
		wr_val    = place_v;
		bus_val   = '0;
		bus_stat  = STAT_OK;
		nxt_count = count_q;
		case (cmd.op)
			OP_EXEC: begin
				unique case (kind_q) inside
					KIND_PUSH: begin
						if (full) begin
							bus_stat = STAT_FULL;
						end else begin
							we        = 1'b1;
							wr_addr   = AW'(count_q);
							nxt_count = count_q + 1'b1;
						end
					end
					KIND_POP, KIND_TOP, KIND_PEEK_MAX, KIND_POP_MAX: begin
						if (empty) begin
							bus_stat = STAT_EMPTY;
						end else if (kind_q == KIND_PEEK_MAX) begin
							bus_val = rd_max_q;
						end else begin
							bus_val = rd_val_q;
							if (kind_q == KIND_POP) nxt_count = count_q - 1'b1;
						end
					end
					default: bus_stat = STAT_OK;
				endcase
			end
			OP_SEARCH_START: begin
				rd_addr_m = top_idx - 1'b1;
			end
			OP_STEP_DOWN: begin
				rd_addr_v = idx_q - 1'b1;
				rd_addr_m = idx_q - AW'(2);
			end
			OP_SHIFT_START: begin
				rd_addr_v = idx_q + 1'b1;
			end
			OP_SHIFT: begin
				we        = 1'b1;
				wr_addr   = idx_q;
				rd_addr_v = idx_q + AW'(2);
				if (cmd.finish) begin
					bus_val   = mx_q;
					nxt_count = count_q - 1'b1;
				end
			end
			OP_POP_DONE: begin
				bus_val   = mx_q;
				nxt_count = count_q - 1'b1;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	// stores
	always_ff @(posedge clk) begin
		if (we) begin
			value_store[wr_addr]       <= wr_val;
			running_max_store[wr_addr] <= place_max;
		end
		rd_val_q <= value_store[rd_addr_v];
		rd_max_q <= running_max_store[rd_addr_m];
	end

	// command, search and shift registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_ACCEPT: begin
				kind_q <= kind;
				val_q  <= push_v;
			end
			OP_SEARCH_START: begin
				mx_q  <= rd_max_q;
				idx_q <= top_idx;
			end
			OP_STEP_DOWN: begin
				idx_q <= idx_q - 1'b1;
			end
			OP_SHIFT_START: begin
				run_q <= rd_max_q;
			end
			OP_SHIFT: begin
				run_q <= place_max;
				idx_q <= idx_q + 1'b1;
			end
			default: begin
				run_q <= run_q;
			end
		endcase
		if (cmd.finish && !out_free) begin
			pend_val_q  <= bus_val32;
			pend_stat_q <= bus_stat;
			pend_cnt_q  <= bus_cnt;
		end
		if (cmd.finish && out_free) begin
			out_val_q  <= bus_val32;
			out_stat_q <= bus_stat;
			out_cnt_q  <= bus_cnt;
		end else if (cmd.op == OP_LOAD_PEND) begin
			out_val_q  <= pend_val_q;
			out_stat_q <= pend_stat_q;
			out_cnt_q  <= pend_cnt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.finish) count_q <= nxt_count;
			if ((cmd.finish && out_free) || (cmd.op == OP_LOAD_PEND)) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign st.exec_popmax = (kind_q == KIND_POP_MAX) && !empty;
	assign st.found       = (rd_val_q == mx_q) || (idx_q == '0);
	assign st.at_top      = (idx_q == top_idx);
	assign st.shift_last  = (AW'(idx_q + 1'b1) == top_idx);
	assign st.out_free    = out_free;

	assign out_valid    = out_valid_q;
	assign result_value = out_val_q;
	assign status       = out_stat_q;
	assign entry_count  = out_cnt_q;

endmodule

// ===== src/max_tracking_stack.sv =====
// max_tracking_stack: top level of the stack that tracks its largest value
// depends on mts_pkg, mts_in_if, mts_out_if, mts_ctrl and mts_datapath
//
// Each command transaction (push, pop, top, peek max, pop max) yields exactly one result
// transaction with the value, a status of ok, empty or full, and the entry count after the
// command. Push, pop, top and peek max pass through a registered read of the value and running
// maximum stores, then an update that produces the result. A pop max on a non-empty stack
// instead follows the read with a downward search for the topmost copy of the maximum and an
// upward shift of the entries above it, each one entry per cycle through the single read port
// of each store. A new command is taken once the previous one has finished and its result has
// entered the output register, where it may still wait. The stores need no clearing after
// reset.
module max_tracking_stack import mts_pkg::*; #(
	parameter int STACK_DEPTH = DEF_STACK_DEPTH,
	parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
	input logic      clk,
	input logic      arst_n,
	mts_in_if.sink   req,
	mts_out_if.source rsp
);

	dp_status_t st;
	ctl_cmd_t   cmd;

	mts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.st       (st),
		.cmd      (cmd)
	);

	mts_datapath #(
		.STACK_DEPTH (STACK_DEPTH),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.kind         (req.kind),
		.push_value   (req.push_value),
		.out_ready    (rsp.ready),
		.cmd          (cmd),
		.st           (st),
		.out_valid    (rsp.valid),
		.result_value (rsp.result_value),
		.status       (rsp.status),
		.entry_count  (rsp.entry_count)
	);

endmodule

// ===== bench/testbench.sv =====
// testbench: self-checking bench for max_tracking_stack, a stack that tracks its largest value
// a scoreboard class predicts every result transaction; tasks drive commands with random idling
// depends on mts_pkg, mts_in_if, mts_out_if and max_tracking_stack
`timescale 1ns / 1ps

module testbench;
	import mts_pkg::*;

	localparam int STACK_DEPTH = DEF_STACK_DEPTH;
	localparam int LONG_HOLD   = 300;
	localparam int END_SLACK   = 40;
	localparam logic signed [DATA_W-1:0] VALUE_MIN = {1'b1, {(DATA_W-1){1'b0}}};
	localparam logic signed [DATA_W-1:0] VALUE_MAX = {1'b0, {(DATA_W-1){1'b1}}};

	typedef struct {
		logic signed [DATA_W-1:0] value;
		logic [STATUS_W-1:0]      status;
		logic [COUNT_W-1:0]       count;
	} stack_result_t;

	class max_stack_scoreboard;
		logic signed [DATA_W-1:0] values[STACK_DEPTH];
		logic signed [DATA_W-1:0] run_max[STACK_DEPTH];
		int fill = 0;
		stack_result_t expected[$];
		int errors = 0;
		int commands = 0;
		int pushes = 0;
		int full_hits = 0;
		int empty_hits = 0;
		int max_pops = 0;
		int deepest_shift = 0;
		int peak_fill = 0;

		function void put_entry(int idx, logic signed [DATA_W-1:0] v);
			run_max[idx] = (idx > 0 && run_max[idx-1] > v) ? run_max[idx-1] : v;
			values[idx] = v;
		endfunction

		function void note_command(logic [KIND_W-1:0] kind, logic signed [DATA_W-1:0] v);
			stack_result_t r;
			logic signed [DATA_W-1:0] mx;
			int t;
			int i;
			r.value = '0;
			r.status = STAT_OK;
			commands++;
			t = fill - 1;
			case (kind) inside
				KIND_PUSH: begin
					pushes++;
					if (fill >= STACK_DEPTH) begin
						r.status = STAT_FULL;
						full_hits++;
					end else begin
						put_entry(fill, v);
						fill++;
					end
				end
				KIND_POP, KIND_TOP, KIND_PEEK_MAX, KIND_POP_MAX: begin
					if (fill == 0) begin
						r.status = STAT_EMPTY;
						empty_hits++;
					end else begin
						case (kind)
							KIND_POP: begin
								r.value = values[t];
								fill = t;
							end
							KIND_TOP: r.value = values[t];
							KIND_PEEK_MAX: r.value = run_max[t];
							default: begin
								mx = run_max[t];
								i = t;
								while (i > 0 && values[i] != mx)
									i--;
								r.value = mx;
								max_pops++;
								if (t - i > deepest_shift)
									deepest_shift = t - i;
								for (int j = i; j < t; j++)
									put_entry(j, values[j+1]);
								fill = t;
							end
						endcase
					end
				end
				default: ;
			endcase
			if (fill > peak_fill)
				peak_fill = fill;
			r.count = COUNT_W'(fill);
			expected.insert(expected.size(), r);
		endfunction

		function void check_result(logic signed [DATA_W-1:0] value, logic [STATUS_W-1:0] status,
			logic [COUNT_W-1:0] count);
			stack_result_t e;
			if (expected.size() == 0) begin
				$error("result transaction with no command outstanding");
				errors++;
				return;
			end
			e = expected[0];
			expected.delete(0);
			if (value !== e.value) begin
				$error("result_value: expected %0d, got %0d", e.value, value);
				errors++;
			end
			if (status !== e.status) begin
				$error("status: expected %0d, got %0d", e.status, status);
				errors++;
			end
			if (count !== e.count) begin
				$error("entry_count: expected %0d, got %0d", e.count, count);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic sink_hold_req;
	logic full_rate;

	mts_in_if req_if ();
	mts_out_if rsp_if ();

	max_tracking_stack #(
		.STACK_DEPTH(STACK_DEPTH),
		.VALUE_WIDTH(DEF_VALUE_WIDTH)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_if),
		.rsp(rsp_if)
	);

	max_stack_scoreboard shadow_stack = new;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (full_rate)
			return 0;
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(12, 40);
	endfunction

	function automatic logic signed [DATA_W-1:0] pick_value();
		case ($urandom_range(0, 7)) inside
			0, 1, 2: return int'($urandom_range(0, 8)) - 4;
			3: begin
				case ($urandom_range(0, 3))
					0: return VALUE_MIN;
					1: return VALUE_MAX;
					2: return '1;
					default: return '0;
				endcase
			end
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [KIND_W-1:0] pick_kind();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40)
			return KIND_PUSH;
		if (r < 52)
			return KIND_POP;
		if (r < 62)
			return KIND_TOP;
		if (r < 72)
			return KIND_PEEK_MAX;
		if (r < 93)
			return KIND_POP_MAX;
		return KIND_W'($urandom_range(int'(KIND_POP_MAX) + 1, (1 << KIND_W) - 1));
	endfunction

	task automatic send_command(input logic [KIND_W-1:0] kind,
		input logic signed [DATA_W-1:0] value);
		int gap;
		gap = idle_len();
		if (gap > 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.kind <= kind;
		req_if.push_value <= value;
		do
			@(posedge clk);
		while (req_if.ready !== 1'b1);
		shadow_stack.note_command(kind, value);
	endtask

	task automatic wait_drained();
		req_if.valid <= 1'b0;
		do
			@(posedge clk);
		while (shadow_stack.expected.size() != 0);
	endtask

	task automatic mixed_run(input int n);
		repeat (n) send_command(pick_kind(), pick_value());
	endtask

	always @(posedge clk)
		if (arst_n && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
			shadow_stack.check_result(rsp_if.result_value, rsp_if.status, rsp_if.entry_count);

	// result sink: random stalls, plus one long hold on request
	initial begin : result_sink
		int n;
		bit held;
		rsp_if.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (sink_hold_req && !held) begin
				held = 1'b1;
				rsp_if.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				rsp_if.ready <= 1'b1;
			end else begin
				n = idle_len();
				if (n == 0) begin
					rsp_if.ready <= 1'b1;
				end else begin
					rsp_if.ready <= 1'b0;
					repeat (n - 1) @(posedge clk);
				end
			end
		end
	end

	initial begin
		#8_000_000;
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		sink_hold_req = 1'b0;
		full_rate = 1'b0;
		req_if.valid = 1'b0;
		req_if.kind = KIND_PUSH;
		req_if.push_value = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// empty stack and unused kinds
		send_command(KIND_POP, '0);
		send_command(KIND_TOP, '0);
		send_command(KIND_PEEK_MAX, '0);
		send_command(KIND_POP_MAX, '0);
		send_command(KIND_W'(KIND_POP_MAX + 1), 32'sh5A5A_5A5A);
		send_command(KIND_W'(KIND_POP_MAX + 2), '1);
		send_command(KIND_W'(KIND_POP_MAX + 3), VALUE_MIN);
		// extremes, equal maxima, deep pop max
		send_command(KIND_PUSH, VALUE_MIN);
		send_command(KIND_PUSH, VALUE_MAX);
		send_command(KIND_PUSH, 5);
		send_command(KIND_PUSH, 5);
		send_command(KIND_PUSH, -7);
		send_command(KIND_PUSH, -1);
		send_command(KIND_PEEK_MAX, '0);
		send_command(KIND_TOP, '0);
		send_command(KIND_POP_MAX, '0);
		send_command(KIND_PEEK_MAX, '0);
		send_command(KIND_POP_MAX, '0);
		send_command(KIND_TOP, '0);
		send_command(KIND_W'(KIND_POP_MAX + 2), '0);
		repeat (4) send_command(KIND_POP, '0);

		mixed_run(20);
		sink_hold_req <= 1'b1;
		mixed_run(30);

		// fill to the top, then push into a full stack
		while (shadow_stack.fill < STACK_DEPTH) begin
			if ($urandom_range(0, 9) == 0)
				send_command($urandom_range(0, 1) ? KIND_TOP : KIND_PEEK_MAX, pick_value());
			else
				send_command(KIND_PUSH, pick_value());
		end
		repeat (3) send_command(KIND_PUSH, pick_value());

		wait_drained();

		// drain to empty through pops and max pops
		while (shadow_stack.fill > 0) begin
			case ($urandom_range(0, 9)) inside
				0, 1, 2, 3, 4: send_command(KIND_POP, pick_value());
				5, 6, 7, 8: send_command(KIND_POP_MAX, pick_value());
				default: send_command($urandom_range(0, 1) ? KIND_TOP : KIND_PEEK_MAX,
					pick_value());
			endcase
		end
		send_command(KIND_POP_MAX, '0);

		full_rate <= 1'b1;
		mixed_run(20);
		full_rate <= 1'b0;
		mixed_run(20);

		wait_drained();
		repeat (END_SLACK) @(posedge clk);

		$display("covered %0d commands: %0d pushes (%0d into a full stack), %0d on an empty stack",
			shadow_stack.commands, shadow_stack.pushes, shadow_stack.full_hits,
			shadow_stack.empty_hits);
		$display("%0d max pops, deepest shift %0d entries, peak depth %0d",
			shadow_stack.max_pops, shadow_stack.deepest_shift, shadow_stack.peak_fill);
		if (shadow_stack.errors == 0 && shadow_stack.expected.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
